### rtl/core/tach_pkg.sv
// ----------------------------------------------------------------------------
// tach_pkg
// Shared types and constants of the fan tachometer rpm meter.
// ----------------------------------------------------------------------------
package tach_pkg;

    localparam int FREQ_WIDTH     = 27;
    localparam int TIMEOUT_WIDTH  = 8;
    localparam int DEBOUNCE_WIDTH = 10;
    localparam int STAMP_IN_WIDTH = 32;
    localparam int RPM_WIDTH      = 32;
    localparam int CFG_DATA_WIDTH = 27;
    localparam int CFG_IDX_WIDTH  = 2;

    // 60 * timer_freq needs 33 bits
    localparam int NUM_WIDTH = FREQ_WIDTH + 6;

    localparam logic [1:0] MODE_EDGE  = 2'd0;
    localparam logic [1:0] MODE_TICK  = 2'd1;
    localparam logic [1:0] MODE_QUERY = 2'd2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_TIMER_FREQ  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_RPM_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DEBOUNCE    = 2'd2;

    localparam logic [FREQ_WIDTH-1:0]     FREQ_RESET     = 27'd10000000;
    localparam logic [TIMEOUT_WIDTH-1:0]  TIMEOUT_RESET  = 8'd20;
    localparam logic [DEBOUNCE_WIDTH-1:0] DEBOUNCE_RESET = 10'd200;

    typedef struct packed {
        logic [1:0]                mode;
        logic                      channel;
        logic [STAMP_IN_WIDTH-1:0] timestamp;
        logic [DEBOUNCE_WIDTH-1:0] high_count;
    } in_item_t;

    typedef struct packed {
        logic [RPM_WIDTH-1:0] rpm;
        logic                 edge_accepted;
        logic                 running;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_MOD,
        ST_TK_RD,
        ST_TK_MOD,
        ST_DIV,
        ST_RESP
    } state_t;

endpackage

### rtl/core/tach_div.sv
// ----------------------------------------------------------------------------
// tach_div
// Restoring divider, one quotient bit per cycle, result saturated to 32 bits.
// ----------------------------------------------------------------------------
module tach_div #(
    parameter int DEN_WIDTH = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tach_pkg::NUM_WIDTH-1:0] numer,
    input  logic [DEN_WIDTH-1:0]           denom,
    output logic                           done,
    output logic [tach_pkg::RPM_WIDTH-1:0] quot
);

    localparam int NW = tach_pkg::NUM_WIDTH;
    localparam int CNT_WIDTH = $clog2(NW + 1);

    logic [DEN_WIDTH-1:0] rem_reg;
    logic [DEN_WIDTH-1:0] rem_next;
    logic [NW-1:0]        quot_reg;
    logic [NW-1:0]        quot_next;
    logic [DEN_WIDTH-1:0] den_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic [CNT_WIDTH-1:0] cnt_next;
    logic                 run_reg;
    logic                 run_next;
    logic                 done_reg;
    logic                 done_next;
    logic [DEN_WIDTH:0]   trial;
    logic [DEN_WIDTH:0]   diff;

    assign trial = {rem_reg, quot_reg[NW-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = numer;
            cnt_next  = CNT_WIDTH'(NW);
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next  = diff[DEN_WIDTH-1:0];
                quot_next = {quot_reg[NW-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[DEN_WIDTH-1:0];
                quot_next = {quot_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_WIDTH'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (start)
        begin
            den_reg <= denom;
        end
    end

    assign done = done_reg;
    // quotients above 32 bits (and a zero divisor) saturate
    assign quot = (quot_reg[NW-1:tach_pkg::RPM_WIDTH] != '0) ? '1
                : quot_reg[tach_pkg::RPM_WIDTH-1:0];

endmodule

### rtl/core/tachometer_rpm_meter.sv
// ----------------------------------------------------------------------------
// tachometer_rpm_meter
// Per-channel fan tachometer: edge periods, poll-driven rpm, timeout.
// ----------------------------------------------------------------------------
// Items are handled one at a time. An edge or a query passes from acceptance
// to result through a read of the channel memory, an update step and the
// load of the output register, which waits while the output stalls. A poll
// tick walks all channels through the same memory port, a read and an update
// step per channel, plus a run of the bit-serial divider for each channel
// that converts a new period.
// The channel state sits in a small synchronous memory; reset marks every
// entry as zero through per-entry valid bits, so no clearing pass is needed.
// Configuration writes are always taken (cfg_ready stays high).
module tachometer_rpm_meter #(
    parameter int CHANNELS    = 2,
    parameter int STAMP_WIDTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tach_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tach_pkg::out_item_t                 out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tach_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
    input  logic [tach_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);

    localparam int SW = (STAMP_WIDTH < tach_pkg::STAMP_IN_WIDTH) ? STAMP_WIDTH
                      : tach_pkg::STAMP_IN_WIDTH;
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef struct packed {
        logic [SW-1:0]                      last_stamp;
        logic [SW-1:0]                      period_count;
        logic                               pulse_pending;
        logic [tach_pkg::TIMEOUT_WIDTH-1:0] timeout_left;
        logic [tach_pkg::RPM_WIDTH-1:0]     rpm_value;
    } entry_t;

    tach_pkg::state_t state_reg;
    tach_pkg::state_t state_next;

    tach_pkg::in_item_t  item_reg;
    tach_pkg::out_item_t res_reg;
    tach_pkg::out_item_t res_next;
    tach_pkg::out_item_t out_reg;
    logic                out_valid_reg;
    logic                out_valid_next;

    logic [CW-1:0] idx_reg;
    logic [CW-1:0] idx_next;
    entry_t        ent_reg;

    logic [tach_pkg::FREQ_WIDTH-1:0]     freq_reg;
    logic [tach_pkg::TIMEOUT_WIDTH-1:0]  tmo_reg;
    logic [tach_pkg::DEBOUNCE_WIDTH-1:0] deb_reg;

    entry_t              mem [CHANNELS];
    logic [CHANNELS-1:0] valid_reg;
    entry_t              rd_data_reg;
    logic                rd_valid_reg;
    logic [CW-1:0]       rd_addr;
    logic                mem_we;
    logic [CW-1:0]       mem_wa;
    entry_t              mem_wd;

    entry_t cur;
    entry_t edge_ent;
    entry_t tick_ent;
    logic   qual;
    logic   later;
    logic   need_div;
    logic   last_chan;
    logic   chan_ok;
    logic   out_free;
    logic [SW-1:0] stamp;

    logic                           div_start;
    logic                           div_done;
    logic [tach_pkg::NUM_WIDTH-1:0] div_numer;
    logic [tach_pkg::RPM_WIDTH-1:0] div_quot;

    tach_div #(
        .DEN_WIDTH(SW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_numer),
        .denom (cur.period_count),
        .done  (div_done),
        .quot  (div_quot)
    );

    // 60 * f as 64 * f - 4 * f
    assign div_numer = (tach_pkg::NUM_WIDTH'(freq_reg) << 6)
                     - (tach_pkg::NUM_WIDTH'(freq_reg) << 2);

    assign cur       = rd_valid_reg ? rd_data_reg : '0;
    assign stamp     = item_reg.timestamp[SW-1:0];
    assign qual      = item_reg.high_count < (deb_reg >> 2);
    assign later     = stamp > cur.last_stamp;
    assign need_div  = cur.pulse_pending && (cur.timeout_left != '0);
    assign last_chan = (32'(idx_reg) == 32'(CHANNELS - 1));
    assign chan_ok   = (32'(in_data.channel) < 32'(CHANNELS));
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        edge_ent = cur;
        if (qual)
        begin
            edge_ent.last_stamp = stamp;
            if (later)
            begin
                edge_ent.period_count  = stamp - cur.last_stamp;
                edge_ent.pulse_pending = 1'b1;
            end
        end
    end

    always_comb
    begin
        tick_ent = cur;
        if (cur.pulse_pending)
        begin
            tick_ent.pulse_pending = 1'b0;
            tick_ent.timeout_left  = tmo_reg;
        end
        else if (cur.timeout_left != '0)
        begin
            tick_ent.timeout_left = cur.timeout_left - 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tach_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.mode) inside
                        tach_pkg::MODE_TICK:
                            state_next = tach_pkg::ST_TK_RD;
                        tach_pkg::MODE_EDGE, tach_pkg::MODE_QUERY:
                            state_next = chan_ok ? tach_pkg::ST_RD : tach_pkg::ST_RESP;
                        default:
                            state_next = tach_pkg::ST_RESP;
                    endcase
                end
            end
            tach_pkg::ST_RD:     state_next = tach_pkg::ST_MOD;
            tach_pkg::ST_MOD:    state_next = tach_pkg::ST_RESP;
            tach_pkg::ST_TK_RD:  state_next = tach_pkg::ST_TK_MOD;
            tach_pkg::ST_TK_MOD:
            begin
                if (need_div)
                begin
                    state_next = tach_pkg::ST_DIV;
                end
                else
                begin
                    state_next = last_chan ? tach_pkg::ST_RESP : tach_pkg::ST_TK_RD;
                end
            end
            tach_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = last_chan ? tach_pkg::ST_RESP : tach_pkg::ST_TK_RD;
                end
            end
            tach_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    state_next = tach_pkg::ST_IDLE;
                end
            end
            default: state_next = tach_pkg::ST_IDLE;
        endcase
    end

    // datapath controls
    always_comb
    begin
        rd_addr        = idx_reg;
        mem_we         = 1'b0;
        mem_wa         = idx_reg;
        mem_wd         = tick_ent;
        div_start      = 1'b0;
        idx_next       = idx_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            tach_pkg::ST_IDLE:
            begin
                idx_next = '0;
                res_next = '0;
            end
            tach_pkg::ST_RD:
            begin
                rd_addr = CW'(item_reg.channel);
            end
            tach_pkg::ST_MOD:
            begin
                mem_wa = CW'(item_reg.channel);
                mem_wd = edge_ent;
                mem_we = (item_reg.mode == tach_pkg::MODE_EDGE);
                if (cur.timeout_left != '0)
                begin
                    res_next.rpm     = cur.rpm_value;
                    res_next.running = 1'b1;
                end
                res_next.edge_accepted = mem_we && qual && later;
            end
            tach_pkg::ST_TK_RD:
            begin
                rd_addr = idx_reg;
            end
            tach_pkg::ST_TK_MOD:
            begin
                if (need_div)
                begin
                    div_start = 1'b1;
                end
                else
                begin
                    mem_we   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            tach_pkg::ST_DIV:
            begin
                mem_wd           = ent_reg;
                mem_wd.rpm_value = div_quot;
                if (div_done)
                begin
                    mem_we   = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            tach_pkg::ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tach_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            idx_reg       <= '0;
            freq_reg      <= tach_pkg::FREQ_RESET;
            tmo_reg       <= tach_pkg::TIMEOUT_RESET;
            deb_reg       <= tach_pkg::DEBOUNCE_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            rd_valid_reg  <= valid_reg[rd_addr];
            if (mem_we)
            begin
                valid_reg[mem_wa] <= 1'b1;
            end
            if (cfg_valid)
            begin
                case (cfg_index)
                    tach_pkg::REG_TIMER_FREQ:  freq_reg <= cfg_data;
                    tach_pkg::REG_RPM_TIMEOUT: tmo_reg  <= cfg_data[tach_pkg::TIMEOUT_WIDTH-1:0];
                    tach_pkg::REG_DEBOUNCE:    deb_reg  <= cfg_data[tach_pkg::DEBOUNCE_WIDTH-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (state_reg == tach_pkg::ST_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (div_start)
        begin
            ent_reg <= tick_ent;
        end
        if (state_reg == tach_pkg::ST_RESP && out_free)
        begin
            out_reg <= res_reg;
        end
    end

    assign in_stall  = (state_reg != tach_pkg::ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

endmodule

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fan tachometer rpm meter. A queue-fed driver
// offers edge, tick, query and unused-mode items; a clocked monitor compares
// every reading against a cycle-free model of the per-channel period, pulse,
// timeout and rpm state. Runs go through several register settings, with
// random idling on both sides, a long output hold-off and full drains.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         NUM_CH      = 2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int         HOLD_CYCLES = 400;
    localparam int         SETTLE      = 100;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_stall;
    tach_pkg::in_item_t                  in_data   = '0;
    logic                                out_valid;
    logic                                out_stall = 1'b0;
    tach_pkg::out_item_t                 out_data;
    logic                                cfg_valid = 1'b0;
    logic                                cfg_ready;
    logic [tach_pkg::CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [tach_pkg::CFG_DATA_WIDTH-1:0] cfg_data  = '0;

    tachometer_rpm_meter #(
        .CHANNELS    (NUM_CH),
        .STAMP_WIDTH (32)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // tachometer model state and register copies
    // ------------------------------------------------------------------
    logic [tach_pkg::FREQ_WIDTH-1:0]     cur_freq     = tach_pkg::FREQ_RESET;
    logic [tach_pkg::TIMEOUT_WIDTH-1:0]  cur_timeout  = tach_pkg::TIMEOUT_RESET;
    logic [tach_pkg::DEBOUNCE_WIDTH-1:0] cur_debounce = tach_pkg::DEBOUNCE_RESET;

    logic [31:0] ch_last    [NUM_CH] = '{default: '0};
    logic [31:0] ch_period  [NUM_CH] = '{default: '0};
    logic        ch_pulse   [NUM_CH] = '{default: 1'b0};
    logic [7:0]  ch_timeout [NUM_CH] = '{default: '0};
    logic [31:0] ch_rpm     [NUM_CH] = '{default: '0};

    int n_edges       = 0;
    int n_periods     = 0;
    int n_ticks       = 0;
    int n_queries     = 0;
    int n_unused      = 0;
    int n_rpm_updates = 0;
    int n_settings    = 1;

    tach_pkg::in_item_t  pending_items[$];
    tach_pkg::out_item_t expected_readings[$];

    int mismatch_count = 0;
    int send_idle_pct  = 33;
    int recv_stall_pct = 33;
    int hold_token     = 0;
    int hold_seen      = 0;
    int hold_left      = 0;

    // stimulus side bookkeeping
    logic [31:0] stim_stamp [NUM_CH] = '{default: '0};
    int          stim_thresh        = int'(tach_pkg::DEBOUNCE_RESET) / 4;

    function automatic logic [31:0] rpm_from_period(input logic [31:0] period);
        logic [63:0] num;
        logic [63:0] quot;
        num = 64'd60 * 64'(cur_freq);
        if (period == '0)
            return '1;
        quot = num / 64'(period);
        if (quot > 64'hFFFF_FFFF)
            return '1;
        return quot[31:0];
    endfunction

    function automatic tach_pkg::out_item_t predict_reading(input tach_pkg::in_item_t item);
        tach_pkg::out_item_t res;
        logic                ch;
        res = '0;
        ch  = item.channel;
        case (item.mode) inside
            tach_pkg::MODE_TICK:
            begin
                n_ticks++;
                for (int c = 0; c < NUM_CH; c++)
                begin
                    if (ch_pulse[c])
                    begin
                        // first pulse after a timeout only restarts the channel
                        if (ch_timeout[c] != '0)
                        begin
                            ch_rpm[c] = rpm_from_period(ch_period[c]);
                            n_rpm_updates++;
                        end
                        ch_timeout[c] = cur_timeout;
                        ch_pulse[c]   = 1'b0;
                    end
                    else if (ch_timeout[c] != '0)
                    begin
                        ch_timeout[c] = ch_timeout[c] - 8'd1;
                    end
                end
            end
            tach_pkg::MODE_EDGE, tach_pkg::MODE_QUERY:
            begin
                if (item.mode == tach_pkg::MODE_EDGE)
                begin
                    n_edges++;
                    if (item.high_count < (cur_debounce >> 2))
                    begin
                        if (item.timestamp > ch_last[ch])
                        begin
                            ch_period[ch]     = item.timestamp - ch_last[ch];
                            ch_pulse[ch]      = 1'b1;
                            res.edge_accepted = 1'b1;
                            n_periods++;
                        end
                        ch_last[ch] = item.timestamp;
                    end
                end
                else
                begin
                    n_queries++;
                end
                if (ch_timeout[ch] != '0)
                begin
                    res.rpm     = ch_rpm[ch];
                    res.running = 1'b1;
                end
            end
            default: n_unused++;
        endcase
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // ------------------------------------------------------------------
    // input driver
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                expected_readings.push_back(predict_reading(in_data));
            if (!in_valid || !in_stall)
            begin
                if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pending_items.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // output monitor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tach_pkg::out_item_t want;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_readings.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected reading rpm=%0d acc=%b run=%b",
                        out_data.rpm, out_data.edge_accepted, out_data.running));
                end
                else
                begin
                    want = expected_readings.pop_front();
                    if (out_data.rpm !== want.rpm)
                        report_mismatch($sformatf("rpm got %0d want %0d",
                            out_data.rpm, want.rpm));
                    if (out_data.edge_accepted !== want.edge_accepted)
                        report_mismatch($sformatf("edge_accepted got %b want %b",
                            out_data.edge_accepted, want.edge_accepted));
                    if (out_data.running !== want.running)
                        report_mismatch($sformatf("running got %b want %b",
                            out_data.running, want.running));
                end
            end
            if (hold_seen != hold_token)
            begin
                hold_seen = hold_token;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_item(input logic [1:0] mode, input logic ch,
                            input logic [31:0] stamp, input logic [9:0] high);
        tach_pkg::in_item_t item;
        item.mode       = mode;
        item.channel    = ch;
        item.timestamp  = stamp;
        item.high_count = high;
        pending_items.push_back(item);
        if (mode == tach_pkg::MODE_EDGE)
            stim_stamp[ch] = stamp;
    endtask

    function automatic logic [31:0] pick_delta();
        case ($urandom_range(3))
            0:       return 32'($urandom_range(1, 200));
            1:       return 32'($urandom_range(200, 50000));
            2:       return 32'($urandom_range(50000, 1 << 24));
            default: return $urandom;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_valid || expected_readings.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [tach_pkg::CFG_IDX_WIDTH-1:0] idx,
                             input logic [tach_pkg::CFG_DATA_WIDTH-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            tach_pkg::REG_TIMER_FREQ:  cur_freq     = value[tach_pkg::FREQ_WIDTH-1:0];
            tach_pkg::REG_RPM_TIMEOUT: cur_timeout  = value[tach_pkg::TIMEOUT_WIDTH-1:0];
            tach_pkg::REG_DEBOUNCE:    cur_debounce = value[tach_pkg::DEBOUNCE_WIDTH-1:0];
            default: ;
        endcase
    endtask

    task automatic queue_random_items(input int count);
        int   kind;
        int   burst;
        logic ch;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(99);
            ch   = 1'($urandom_range(1));
            if (kind < 45)
            begin
                add_item(tach_pkg::MODE_EDGE, ch, stim_stamp[ch] + pick_delta(),
                         10'($urandom_range(0, stim_thresh - 1)));
            end
            else if (kind < 60)
            begin
                // tick bursts let short timeouts run out
                burst = $urandom_range(1, 3);
                repeat (burst)
                    add_item(tach_pkg::MODE_TICK, 1'($urandom_range(1)), $urandom,
                             10'($urandom_range(1023)));
                n += burst - 1;
            end
            else if (kind < 80)
            begin
                add_item(tach_pkg::MODE_QUERY, ch, $urandom, 10'($urandom_range(1023)));
            end
            else if (kind < 92)
            begin
                add_item(tach_pkg::MODE_EDGE, ch, stim_stamp[ch] + pick_delta(),
                         10'($urandom_range(1023)));
            end
            else if (kind < 97)
            begin
                add_item(tach_pkg::MODE_EDGE, ch, $urandom,
                         10'($urandom_range(0, stim_thresh - 1)));
            end
            else
            begin
                add_item(MODE_UNUSED, ch, $urandom, 10'($urandom_range(1023)));
            end
        end
    endtask

    task automatic run_phase(input int freq, input int tmo, input int deb, input int count,
                             input int idle_pct, input bit hold, input bit split);
        write_reg(tach_pkg::REG_TIMER_FREQ, tach_pkg::CFG_DATA_WIDTH'(freq));
        write_reg(tach_pkg::REG_RPM_TIMEOUT, tach_pkg::CFG_DATA_WIDTH'(tmo));
        write_reg(tach_pkg::REG_DEBOUNCE, tach_pkg::CFG_DATA_WIDTH'(deb));
        n_settings++;
        stim_thresh    = deb / 4;
        send_idle_pct  = idle_pct;
        recv_stall_pct = idle_pct;
        if (split)
        begin
            queue_random_items(count / 2);
            wait_drained();
            queue_random_items(count - count / 2);
        end
        else
        begin
            queue_random_items(count);
        end
        if (hold)
            hold_token++;
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed part at reset settings: 10 MHz, timeout 20, 200 samples
        add_item(tach_pkg::MODE_QUERY, 1'b0, 32'd0, 10'd0);
        add_item(tach_pkg::MODE_QUERY, 1'b1, 32'hFFFF_FFFF, 10'd1023);
        add_item(tach_pkg::MODE_EDGE,  1'b0, 32'd1000, 10'd0);
        add_item(tach_pkg::MODE_TICK,  1'b0, 32'd0, 10'd0);       // first pulse, no rpm yet
        add_item(tach_pkg::MODE_EDGE,  1'b0, 32'd11000, 10'd49);  // just below threshold
        add_item(tach_pkg::MODE_TICK,  1'b1, 32'hFFFF_FFFF, 10'd1023);
        add_item(tach_pkg::MODE_QUERY, 1'b0, 32'd0, 10'd0);
        add_item(tach_pkg::MODE_EDGE,  1'b0, 32'd20000, 10'd50);  // at threshold, rejected
        add_item(tach_pkg::MODE_EDGE,  1'b0, 32'd21000, 10'd1023);
        add_item(tach_pkg::MODE_EDGE,  1'b0, 32'd21000, 10'd0);
        add_item(tach_pkg::MODE_EDGE,  1'b0, 32'd21000, 10'd0);   // equal stamp, no period
        add_item(tach_pkg::MODE_EDGE,  1'b0, 32'd500, 10'd0);     // wrapped stamp skipped
        add_item(tach_pkg::MODE_EDGE,  1'b0, 32'd600, 10'd0);
        add_item(tach_pkg::MODE_EDGE,  1'b0, 32'd610, 10'd0);     // latest of several pulses wins
        add_item(tach_pkg::MODE_TICK,  1'b0, 32'd0, 10'd0);
        add_item(tach_pkg::MODE_EDGE,  1'b1, 32'hFFFF_FFFF, 10'd0);
        add_item(tach_pkg::MODE_TICK,  1'b0, 32'd0, 10'd0);
        add_item(tach_pkg::MODE_EDGE,  1'b1, 32'd0, 10'd0);
        add_item(tach_pkg::MODE_EDGE,  1'b1, 32'd1, 10'd0);       // one-count period
        add_item(tach_pkg::MODE_TICK,  1'b0, 32'd0, 10'd0);
        add_item(tach_pkg::MODE_QUERY, 1'b1, 32'd0, 10'd0);
        add_item(MODE_UNUSED,          1'b1, 32'hFFFF_FFFF, 10'd1023);
        add_item(tach_pkg::MODE_TICK,  1'b1, 32'd0, 10'd0);
        add_item(tach_pkg::MODE_TICK,  1'b0, 32'd0, 10'd0);
        add_item(tach_pkg::MODE_QUERY, 1'b0, 32'd0, 10'd0);
        wait_drained();
        stim_stamp[0] = 32'd610;
        stim_stamp[1] = 32'd1;

        run_phase(10000000, 20, 200, 180, 33, 1'b0, 1'b0);
        run_phase(71582788, 0, 4, 200, 0, 1'b0, 1'b0);
        run_phase(1, 255, 1023, 200, 33, 1'b1, 1'b0);
        run_phase($urandom_range(1, 71582788), 1, $urandom_range(4, 1023), 220, 33,
                  1'b0, 1'b0);
        run_phase($urandom_range(1, 71582788), $urandom_range(2, 10),
                  $urandom_range(4, 1023), 300, 33, 1'b1, 1'b1);
        run_phase(10000000, 3, 200, 300, 33, 1'b0, 1'b0);

        repeat (SETTLE) @(posedge clk);

        $display("covered %0d edges (%0d gave a period), %0d ticks, %0d queries, %0d unused",
                 n_edges, n_periods, n_ticks, n_queries, n_unused);
        $display("%0d rpm conversions over %0d register settings, %0d mismatches",
                 n_rpm_updates, n_settings, mismatch_count);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule
